FILE: hw/rtl/bcs_pkg.sv
package bcs_pkg;

    localparam int OFFSET_BITS_DEFAULT = 16;
    localparam int DIRECTIVE_LEN = 5;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_SLASH = 8'h2f;
    localparam logic [7:0] CHAR_STAR  = 8'h2a;
    localparam logic [7:0] CHAR_HASH  = 8'h23;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_SLASH = 3'd1,
        MODE_HASH  = 3'd2,
        MODE_LINE  = 3'd3,
        MODE_BLOCK = 3'd4,
        MODE_BSTAR = 3'd5
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       is_last;
    } in_beat_t;

    typedef struct packed {
        logic [15:0] start_offset;
        logic        found;
    } out_beat_t;

    function automatic logic [7:0] directive_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h23;
            3'd1:    c = 8'h6c;
            3'd2:    c = 8'h69;
            3'd3:    c = 8'h6e;
            3'd4:    c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: hw/rtl/bcs_scan_core.sv
module bcs_scan_core #(
    parameter int OFFSET_BITS = bcs_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  bcs_pkg::in_beat_t beat,
    output logic              emit,
    output bcs_pkg::out_beat_t result
);
    import bcs_pkg::*;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

    scan_mode_t             mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] position_reg, position_next;
    logic [OFFSET_BITS-1:0] pending_reg, pending_next;
    logic [2:0]             count_reg, count_next;
    logic                   decided_reg, decided_next;

    logic [OFFSET_BITS-1:0] here_inc;
    logic [OFFSET_BITS-1:0] off;
    logic [31:0]            off_wide;
    logic                   fnd;
    logic                   blank;
    logic [7:0]             c;

    assign c        = beat.byte_in;
    assign here_inc = (position_reg == OFFSET_MAX) ? OFFSET_MAX : position_reg + 1'b1;
    assign blank    = c inside {CHAR_SPACE, CHAR_TAB, CHAR_CR, CHAR_LF};

    always_comb begin
        mode_next    = mode_reg;
        pending_next = pending_reg;
        count_next   = count_reg;
        decided_next = decided_reg;
        emit         = 1'b0;
        off          = '0;
        fnd          = 1'b0;
        if (!decided_reg) begin
            case (mode_reg)
                MODE_SLASH: begin
                    if (c == CHAR_SLASH) begin
                        mode_next = MODE_LINE;
                    end else if (c == CHAR_STAR) begin
                        mode_next = MODE_BLOCK;
                    end else begin
                        decided_next = 1'b1;
                        emit         = 1'b1;
                        off          = pending_reg;
                        fnd          = 1'b1;
                    end
                end
                MODE_HASH: begin
                    if (count_reg < 3'(DIRECTIVE_LEN) && c == directive_char(count_reg)) begin
                        if (count_reg + 3'd1 >= 3'(DIRECTIVE_LEN)) begin
                            mode_next  = MODE_LINE;
                            count_next = '0;
                        end else begin
                            count_next = count_reg + 3'd1;
                        end
                    end else begin
                        decided_next = 1'b1;
                        emit         = 1'b1;
                        off          = pending_reg;
                        fnd          = 1'b1;
                    end
                end
                MODE_LINE: begin
                    if (c == CHAR_CR || c == CHAR_LF) begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_BLOCK: begin
                    if (c == CHAR_STAR) begin
                        mode_next = MODE_BSTAR;
                    end
                end
                MODE_BSTAR: begin
                    if (c == CHAR_SLASH) begin
                        mode_next = MODE_IDLE;
                    end else if (c != CHAR_STAR) begin
                        mode_next = MODE_BLOCK;
                    end
                end
                default: begin
                    mode_next = MODE_IDLE;
                    if (blank) begin
                        mode_next = MODE_IDLE;
                    end else if (c == CHAR_SLASH) begin
                        pending_next = position_reg;
                        mode_next    = MODE_SLASH;
                    end else if (c == CHAR_HASH) begin
                        pending_next = position_reg;
                        count_next   = 3'd1;
                        mode_next    = MODE_HASH;
                    end else begin
                        decided_next = 1'b1;
                        emit         = 1'b1;
                        off          = position_reg;
                        fnd          = 1'b1;
                    end
                end
            endcase
            if (beat.is_last && !decided_next) begin
                emit = 1'b1;
                if (mode_next == MODE_SLASH || mode_next == MODE_HASH) begin
                    off = pending_next;
                    fnd = 1'b1;
                end else begin
                    off = here_inc;
                    fnd = 1'b0;
                end
            end
        end
        position_next = here_inc;
        if (beat.is_last) begin
            mode_next     = MODE_IDLE;
            position_next = '0;
            pending_next  = '0;
            count_next    = '0;
            decided_next  = 1'b0;
        end
    end

    assign off_wide            = 32'(off);
    assign result.start_offset = off_wide[15:0];
    assign result.found        = fnd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            position_reg <= '0;
            pending_reg  <= '0;
            count_reg    <= '0;
            decided_reg  <= 1'b0;
        end else if (step_en) begin
            mode_reg     <= mode_next;
            position_reg <= position_next;
            pending_reg  <= pending_next;
            count_reg    <= count_next;
            decided_reg  <= decided_next;
        end
    end

endmodule

FILE: hw/rtl/blank_and_comment_skipper_unit.sv
// A deciding beat waits in the input register until the result register is free;
// its result is then registered. Throughput: one byte per cycle while no result
// is held or m_ready is high, set by the scan state update between the registers.
// Reset: synchronous active-low aresetn clears the scan state and both valid flags;
// the first beat after reset starts a new string.
module blank_and_comment_skipper_unit #(
    parameter int OFFSET_BITS = bcs_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bcs_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bcs_pkg::out_beat_t m_data
);
    import bcs_pkg::*;

    logic      in_valid_reg, in_valid_next;
    in_beat_t  in_data_reg;
    logic      out_valid_reg, out_valid_next;
    out_beat_t out_data_reg;
    logic      fire;
    logic      emit;
    out_beat_t result;

    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    bcs_scan_core #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (fire),
        .beat    (in_data_reg),
        .emit    (emit),
        .result  (result)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (fire) begin
            out_valid_next = emit;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (fire && emit) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

`ifndef ASSERT_OFF
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input stage empty but not ready");

    a_result_from_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(fire && emit))
        else $error("result appeared without a scan step");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && emit) |-> (!out_valid_reg || m_ready))
        else $error("pending result overwritten");
`endif

endmodule
